// ----- rtl/icp_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// icp_pkg
// shared types and constants for the ir pulse capture block
// ---------------------------------------------------------------------------
package icp_pkg;

    localparam int STORE_DEPTH      = 128;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int CNT_W            = ADDR_W + 1;
    localparam int MIN_HASH_ENTRIES = 10;
    localparam int WIDTH_W          = 16;
    localparam int HASH_W           = 32;
    localparam int GAP_RESET        = 100;

    localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;
    localparam logic [HASH_W-1:0] HASH_BASIS = 32'd2166136261;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_RESUME = 3'd1,
        OP_PAUSE  = 3'd2,
        OP_READ   = 3'd3,
        OP_HASH   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_TOO_SHORT = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MARK  = 2'd1,
        PH_SPACE = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_READ = 2'd1,
        CTL_HASH = 2'd2
    } ctl_t;

    // read port request of the width store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

    // hash walk request and response
    typedef struct packed {
        logic              start;
        logic [ADDR_W-1:0] last;
    } hsh_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] value;
    } hsh_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/icp_width_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// icp_width_ram
// width store: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module icp_width_ram (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [icp_pkg::ADDR_W-1:0]   wr_addr,
    input  wire logic [icp_pkg::WIDTH_W-1:0]  wr_data,
    input  wire icp_pkg::ram_rd_t             rd,
    output logic      [icp_pkg::WIDTH_W-1:0]  rd_data
);
    import icp_pkg::*;

    logic [WIDTH_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/icp_hash_walk.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// icp_hash_walk
// walks the width store once and folds the width classes into an fnv-1 hash
// ---------------------------------------------------------------------------
module icp_hash_walk (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire icp_pkg::hsh_req_t            req,
    output icp_pkg::ram_rd_t                  rd,
    input  wire logic [icp_pkg::WIDTH_W-1:0]  rd_data,
    output icp_pkg::hsh_rsp_t                 rsp
);
    import icp_pkg::*;

    logic              active_reg;
    logic [ADDR_W-1:0] issue_reg;
    logic [ADDR_W-1:0] last_reg;
    logic              vld_reg;
    logic [ADDR_W-1:0] didx_reg;
    logic              done_reg;
    logic [WIDTH_W-1:0] w1_reg;
    logic [WIDTH_W-1:0] w2_reg;
    logic [HASH_W-1:0]  hash_reg;

    logic [WIDTH_W+2:0] new5;
    logic [WIDTH_W+2:0] old4;
    logic [WIDTH_W+2:0] old5;
    logic [WIDTH_W+2:0] new4;
    logic [1:0]         cls;
    logic [HASH_W-1:0]  hash_next;

    assign rd.en   = active_reg;
    assign rd.addr = issue_reg;

    // compare each width with the one two entries later, 20% tolerance
    assign new5 = ({3'b000, rd_data} << 2) + {3'b000, rd_data};
    assign new4 = {1'b0, rd_data, 2'b00};
    assign old5 = ({3'b000, w2_reg} << 2) + {3'b000, w2_reg};
    assign old4 = {1'b0, w2_reg, 2'b00};

    always_comb
    begin
        priority if (new5 < old4)
        begin
            cls = 2'd0;
        end
        else if (old5 < new4)
        begin
            cls = 2'd2;
        end
        else
        begin
            cls = 2'd1;
        end
    end

    assign hash_next = HASH_W'(hash_reg * HASH_PRIME) ^ {{(HASH_W-2){1'b0}}, cls};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            vld_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            vld_reg  <= active_reg;
            done_reg <= vld_reg && (didx_reg == last_reg);
            if (req.start)
            begin
                active_reg <= 1'b1;
            end
            else if (active_reg && (issue_reg == last_reg))
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg <= issue_reg;
        if (req.start)
        begin
            issue_reg <= ADDR_W'(1);
            last_reg  <= req.last;
            hash_reg  <= HASH_BASIS;
        end
        else
        begin
            if (active_reg)
            begin
                issue_reg <= issue_reg + ADDR_W'(1);
            end
            if (vld_reg)
            begin
                w1_reg <= rd_data;
                w2_reg <= w1_reg;
                if (didx_reg >= ADDR_W'(3))
                begin
                    hash_reg <= hash_next;
                end
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = hash_reg;

endmodule
`default_nettype wire

// ----- rtl/ir_pulse_capture_with_hash.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ir_pulse_capture_with_hash
// infrared receiver raw pulse capture with a frame hash
// ---------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low. Every
// item gives exactly one result, shown for a single cycle with done high; the
// receiver cannot hold it off, so it must take it in that cycle. Tick,
// resume, pause, unused codes and failed operations are answered from the
// edge that takes them: busy stays low and the next item may follow straight
// away. A read passes the registered store read port, then the result
// register. A successful hash reads one store entry per cycle from entry 1
// to the last one, then passes the read port and result registers. The gap
// threshold must be written through cfg_we / cfg_data only while no item is
// in progress; the block does not enforce this. The store needs no clearing
// after reset, as only entries of the current frame are ever read.
// ---------------------------------------------------------------------------
module ir_pulse_capture_with_hash (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [2:0]                   operation,
    input  wire logic                         level,
    input  wire logic [icp_pkg::ADDR_W-1:0]   index,
    input  wire logic                         cfg_we,
    input  wire logic [icp_pkg::WIDTH_W-1:0]  cfg_data,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [1:0]                        capture_phase,
    output logic [icp_pkg::CNT_W-1:0]         entry_total,
    output logic [icp_pkg::WIDTH_W-1:0]       read_width,
    output logic [icp_pkg::HASH_W-1:0]        hash_value
);
    import icp_pkg::*;

    // control and capture state
    ctl_t               ctl_reg, ctl_next;
    phase_t             phase_reg, phase_next;
    logic [WIDTH_W-1:0] timer_reg, timer_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [WIDTH_W-1:0] gap_reg;

    // result registers
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [WIDTH_W-1:0] rdw_reg, rdw_next;
    logic [HASH_W-1:0]  hv_reg, hv_next;

    // store ports
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WIDTH_W-1:0] wr_data;
    ram_rd_t            rd;
    ram_rd_t            hsh_rd;
    logic [WIDTH_W-1:0] rd_data;
    logic               top_rd_en;

    hsh_req_t           hsh_req;
    hsh_rsp_t           hsh_rsp;

    logic               accept;
    op_t                op;
    logic [WIDTH_W-1:0] timer_inc;
    phase_t             ph_eff;
    logic               read_ok;
    logic               hash_go;

    assign accept = start && (ctl_reg == CTL_IDLE);
    assign busy   = (ctl_reg != CTL_IDLE);
    assign op     = op_t'(operation);

    // tick timer saturates instead of wrapping
    assign timer_inc = (timer_reg == '1) ? timer_reg : timer_reg + WIDTH_W'(1);
    // a full store forces the stop phase before the tick is handled
    assign ph_eff    = count_reg[CNT_W-1] ? PH_STOP : phase_reg;

    assign read_ok = ({1'b0, index} < count_reg);
    assign hash_go = (phase_reg == PH_STOP) && (count_reg >= CNT_W'(MIN_HASH_ENTRIES));

    // next control state
    always_comb
    begin
        ctl_next = ctl_reg;
        unique case (ctl_reg)
            CTL_IDLE:
            begin
                if (accept && (op == OP_READ) && read_ok)
                begin
                    ctl_next = CTL_READ;
                end
                else if (accept && (op == OP_HASH) && hash_go)
                begin
                    ctl_next = CTL_HASH;
                end
            end
            CTL_READ:
            begin
                ctl_next = CTL_IDLE;
            end
            CTL_HASH:
            begin
                if (hsh_rsp.done)
                begin
                    ctl_next = CTL_IDLE;
                end
            end
            default:
            begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    // capture datapath and result values
    always_comb
    begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        count_next    = count_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_data       = timer_inc;
        top_rd_en     = 1'b0;
        hsh_req.start = 1'b0;
        hsh_req.last  = count_reg[ADDR_W-1:0] - ADDR_W'(1);
        done_next     = 1'b0;
        status_next   = ST_OK;
        rdw_next      = '0;
        hv_next       = '0;

        unique case (ctl_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_TICK:
                        begin
                            done_next  = 1'b1;
                            timer_next = timer_inc;
                            phase_next = ph_eff;
                            unique case (ph_eff)
                                PH_IDLE:
                                begin
                                    if (!level)
                                    begin
                                        timer_next = '0;
                                        // gap long enough: it opens the frame as entry 0
                                        if (timer_inc >= gap_reg)
                                        begin
                                            wr_en      = 1'b1;
                                            wr_addr    = '0;
                                            count_next = CNT_W'(1);
                                            phase_next = PH_MARK;
                                        end
                                    end
                                end
                                PH_MARK:
                                begin
                                    if (level)
                                    begin
                                        wr_en      = 1'b1;
                                        count_next = count_reg + CNT_W'(1);
                                        timer_next = '0;
                                        phase_next = PH_SPACE;
                                    end
                                end
                                PH_SPACE:
                                begin
                                    if (!level)
                                    begin
                                        wr_en      = 1'b1;
                                        count_next = count_reg + CNT_W'(1);
                                        timer_next = '0;
                                        phase_next = PH_MARK;
                                    end
                                    else if (timer_inc > gap_reg)
                                    begin
                                        // long space ends the frame, timer runs on
                                        phase_next = PH_STOP;
                                    end
                                end
                                PH_STOP:
                                begin
                                    if (!level)
                                    begin
                                        timer_next = '0;
                                    end
                                end
                                default:
                                begin
                                    phase_next = ph_eff;
                                end
                            endcase
                        end
                        OP_RESUME:
                        begin
                            done_next  = 1'b1;
                            phase_next = PH_IDLE;
                            count_next = '0;
                        end
                        OP_PAUSE:
                        begin
                            done_next  = 1'b1;
                            phase_next = PH_STOP;
                            count_next = '0;
                        end
                        OP_READ:
                        begin
                            if (read_ok)
                            begin
                                top_rd_en = 1'b1;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_INDEX;
                            end
                        end
                        OP_HASH:
                        begin
                            if (phase_reg != PH_STOP)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_READY;
                            end
                            else if (!hash_go)
                            begin
                                // too few entries: frame is dropped
                                done_next   = 1'b1;
                                status_next = ST_TOO_SHORT;
                                phase_next  = PH_IDLE;
                                count_next  = '0;
                            end
                            else
                            begin
                                hsh_req.start = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            CTL_READ:
            begin
                done_next = 1'b1;
                rdw_next  = rd_data;
            end
            CTL_HASH:
            begin
                if (hsh_rsp.done)
                begin
                    done_next  = 1'b1;
                    hv_next    = hsh_rsp.value;
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // store read port: hash walk owns it while hashing
    always_comb
    begin
        if (ctl_reg == CTL_HASH)
        begin
            rd = hsh_rd;
        end
        else
        begin
            rd.en   = top_rd_en;
            rd.addr = index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= CTL_IDLE;
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            count_reg <= '0;
            gap_reg   <= WIDTH_W'(GAP_RESET);
            done_reg  <= 1'b0;
        end
        else
        begin
            ctl_reg   <= ctl_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                gap_reg <= cfg_data;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rdw_reg    <= rdw_next;
        hv_reg     <= hv_next;
    end

    icp_width_ram u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd      (rd),
        .rd_data (rd_data)
    );

    icp_hash_walk u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (hsh_req),
        .rd      (hsh_rd),
        .rd_data (rd_data),
        .rsp     (hsh_rsp)
    );

    assign done          = done_reg;
    assign status        = status_reg;
    assign capture_phase = phase_reg;
    assign entry_total   = count_reg;
    assign read_width    = rdw_reg;
    assign hash_value    = hv_reg;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the ir pulse capture block with frame hash
// ---------------------------------------------------------------------------
// Items go in through the start/busy handshake, and every result strobe is
// checked field by field against a behavioural copy of the capture engine
// kept in this bench. A short table of directed items comes first. Then
// several stretches of random traffic follow, each under its own gap
// threshold. Most of that traffic is well-formed frames with random widths
// and the rest is noise. One short stretch under the largest threshold checks
// that marks cannot open a frame there.
// ---------------------------------------------------------------------------
module tb_top;
    import icp_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 1000000;
    // the longest item is a hash over a full store
    localparam int DRAIN_CYCLES = STORE_DEPTH + 12;

    // operation codes the block leaves unused
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // width classes folded into the frame hash
    localparam logic [1:0] CLS_SHORTER = 2'd0;
    localparam logic [1:0] CLS_SAME    = 2'd1;
    localparam logic [1:0] CLS_LONGER  = 2'd2;

    localparam logic [WIDTH_W-1:0] GAP_MIN   = 16'd1;
    localparam logic [WIDTH_W-1:0] GAP_MAX   = 16'hFFFF;
    localparam logic [WIDTH_W-1:0] TIMER_MAX = 16'hFFFF;

    typedef struct packed {
        status_t            status;
        phase_t             phase;
        logic [CNT_W-1:0]   total;
        logic [WIDTH_W-1:0] width;
        logic [HASH_W-1:0]  hash;
    } capture_result_t;

    typedef struct packed {
        logic [2:0]        op;
        logic              lvl;
        logic [ADDR_W-1:0] idx;
        logic              typed;
        capture_result_t   want;
    } stimulus_row_t;

    // directed items; rows with typed set carry their own expected result,
    // the others are left to the capture model
    localparam int DIRECTED_ROWS = 16;
    localparam stimulus_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        // hash and reads straight out of reset
        '{OP_HASH,    1'b0, 7'd0,   1'b1, '{ST_NOT_READY, PH_IDLE,  8'd0, 16'd0, 32'd0}},
        '{OP_READ,    1'b0, 7'd0,   1'b1, '{ST_BAD_INDEX, PH_IDLE,  8'd0, 16'd0, 32'd0}},
        '{OP_READ,    1'b1, 7'd127, 1'b1, '{ST_BAD_INDEX, PH_IDLE,  8'd0, 16'd0, 32'd0}},
        // unused codes change nothing
        '{OP_SPARE_7, 1'b1, 7'd127, 1'b1, '{ST_OK,        PH_IDLE,  8'd0, 16'd0, 32'd0}},
        '{OP_SPARE_5, 1'b0, 7'h55,  1'b1, '{ST_OK,        PH_IDLE,  8'd0, 16'd0, 32'd0}},
        '{OP_SPARE_6, 1'b1, 7'h2A,  1'b1, '{ST_OK,        PH_IDLE,  8'd0, 16'd0, 32'd0}},
        // a mark well short of the gap keeps the engine idle
        '{OP_TICK,    1'b0, 7'd0,   1'b1, '{ST_OK,        PH_IDLE,  8'd0, 16'd0, 32'd0}},
        '{OP_TICK,    1'b1, 7'd127, 1'b0, '{ST_OK,        PH_IDLE,  8'd0, 16'd0, 32'd0}},
        // pause, then reads, ticks and a hash while stopped and empty
        '{OP_PAUSE,   1'b0, 7'd0,   1'b1, '{ST_OK,        PH_STOP,  8'd0, 16'd0, 32'd0}},
        '{OP_READ,    1'b0, 7'd0,   1'b1, '{ST_BAD_INDEX, PH_STOP,  8'd0, 16'd0, 32'd0}},
        '{OP_TICK,    1'b0, 7'd0,   1'b1, '{ST_OK,        PH_STOP,  8'd0, 16'd0, 32'd0}},
        '{OP_TICK,    1'b1, 7'd0,   1'b0, '{ST_OK,        PH_IDLE,  8'd0, 16'd0, 32'd0}},
        '{OP_HASH,    1'b0, 7'd0,   1'b1, '{ST_TOO_SHORT, PH_IDLE,  8'd0, 16'd0, 32'd0}},
        '{OP_HASH,    1'b1, 7'd127, 1'b1, '{ST_NOT_READY, PH_IDLE,  8'd0, 16'd0, 32'd0}},
        '{OP_PAUSE,   1'b1, 7'd0,   1'b1, '{ST_OK,        PH_STOP,  8'd0, 16'd0, 32'd0}},
        '{OP_RESUME,  1'b0, 7'd127, 1'b1, '{ST_OK,        PH_IDLE,  8'd0, 16'd0, 32'd0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0] operation = '0;
    logic level = 1'b0;
    logic [ADDR_W-1:0] index = '0;
    logic cfg_we = 1'b0;
    logic [WIDTH_W-1:0] cfg_data = '0;

    logic busy;
    logic done;
    logic [1:0] status;
    logic [1:0] capture_phase;
    logic [CNT_W-1:0] entry_total;
    logic [WIDTH_W-1:0] read_width;
    logic [HASH_W-1:0] hash_value;

    // capture model state, kept in step with every accepted item
    phase_t             cap_phase;
    logic [WIDTH_W-1:0] cap_timer;
    int                 cap_count;
    logic [WIDTH_W-1:0] cap_widths [STORE_DEPTH];
    logic [WIDTH_W-1:0] cap_gap;

    // results still owed by the block, oldest first
    capture_result_t awaited_results [$];

    int fail_count = 0;
    int item_count = 0;
    int result_count = 0;
    int hash_ok_count = 0;
    int read_ok_count = 0;
    int store_full_count = 0;
    int cycle_count = 0;
    bit sender_idling = 1'b1;

    ir_pulse_capture_with_hash u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .level         (level),
        .index         (index),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .capture_phase (capture_phase),
        .entry_total   (entry_total),
        .read_width    (read_width),
        .hash_value    (hash_value)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // a hard stop in case the handshake or the result strobe hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timed out after %0d cycles, %0d results still owed", $time,
                     cycle_count, awaited_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // records the running tick count as the next width, while there is room
    task automatic store_width();
        if (cap_count < STORE_DEPTH)
        begin
            cap_widths[cap_count] = cap_timer;
            cap_count++;
            if (cap_count == STORE_DEPTH)
                store_full_count++;
        end
        cap_timer = '0;
    endtask

    // advances the capture model by one item and works out its result
    task automatic capture_step(input logic [2:0] op, input logic lvl,
                                input logic [ADDR_W-1:0] idx, output capture_result_t res);
        logic [HASH_W-1:0] sig;
        logic [1:0]        cls;
        int unsigned       w_old;
        int unsigned       w_new;
        res.status = ST_OK;
        res.width  = '0;
        res.hash   = '0;
        case (op)
            OP_TICK:
            begin
                // the timer pins at its ceiling rather than wrapping
                if (cap_timer != TIMER_MAX)
                    cap_timer = cap_timer + 1'b1;
                // a full store forces the frame to end
                if (cap_count >= STORE_DEPTH)
                    cap_phase = PH_STOP;
                case (cap_phase)
                    PH_IDLE:
                        if (!lvl)
                        begin
                            // a mark after a short gap is ignored, a long one opens a frame
                            if (cap_timer < cap_gap)
                                cap_timer = '0;
                            else
                            begin
                                cap_count = 0;
                                store_width();
                                cap_phase = PH_MARK;
                            end
                        end
                    PH_MARK:
                        if (lvl)
                        begin
                            store_width();
                            cap_phase = PH_SPACE;
                        end
                    PH_SPACE:
                        if (!lvl)
                        begin
                            store_width();
                            cap_phase = PH_MARK;
                        end
                        else if (cap_timer > cap_gap)
                            cap_phase = PH_STOP;
                    default:
                        // marks while stopped only restart the timer
                        if (!lvl)
                            cap_timer = '0;
                endcase
            end
            OP_RESUME:
            begin
                cap_phase = PH_IDLE;
                cap_count = 0;
            end
            OP_PAUSE:
            begin
                cap_phase = PH_STOP;
                cap_count = 0;
            end
            OP_READ:
                if (idx >= cap_count)
                    res.status = ST_BAD_INDEX;
                else
                begin
                    res.width = cap_widths[idx];
                    read_ok_count++;
                end
            OP_HASH:
                if (cap_phase != PH_STOP)
                    res.status = ST_NOT_READY;
                else
                begin
                    if (cap_count < MIN_HASH_ENTRIES)
                        res.status = ST_TOO_SHORT;
                    else
                    begin
                        // each width from entry 1 on is classed against the one two later
                        sig = HASH_BASIS;
                        for (int i = 1; i + 2 < cap_count; i++)
                        begin
                            w_old = cap_widths[i];
                            w_new = cap_widths[i + 2];
                            if (5 * w_new < 4 * w_old)
                                cls = CLS_SHORTER;
                            else if (5 * w_old < 4 * w_new)
                                cls = CLS_LONGER;
                            else
                                cls = CLS_SAME;
                            sig = (sig * HASH_PRIME) ^ {30'd0, cls};
                        end
                        res.hash = sig;
                        hash_ok_count++;
                    end
                    // the frame is dropped whether or not the hash succeeded
                    cap_phase = PH_IDLE;
                    cap_count = 0;
                end
            default:
                ;
        endcase
        res.phase = cap_phase;
        res.total = CNT_W'(cap_count);
    endtask

    // offers one item after a random pause and waits for the block to take it;
    // start is lowered only when a pause really follows, so it never drops and
    // rises within the same edge
    task automatic send_item(input logic [2:0] op, input logic lvl,
                             input logic [ADDR_W-1:0] idx, input logic typed = 1'b0,
                             input capture_result_t typed_result = '0);
        int              pause_len;
        capture_result_t predicted;
        pause_len = sender_idling ? $urandom_range(0, 3) : 0;
        if (pause_len > 0)
        begin
            start <= 1'b0;
            repeat (pause_len) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        level     <= lvl;
        index     <= idx;
        do @(posedge clk); while (busy !== 1'b0);
        capture_step(op, lvl, idx, predicted);
        awaited_results.push_back(typed ? typed_result : predicted);
        item_count++;
    endtask

    // a run of ticks at one level, with junk on the unused index
    task automatic send_run(input logic lvl, input int len);
        repeat (len)
            send_item(OP_TICK, lvl, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
    endtask

    // gap, alternating marks and spaces, a closing mark, then a space long
    // enough to stop the frame
    task automatic send_frame(input int pulses, input int mark_top);
        send_run(1'b1, cap_gap + $urandom_range(0, 2));
        for (int p = 0; p < pulses; p++)
        begin
            send_run(1'b0, $urandom_range(1, mark_top));
            // up to one tick past the threshold, which still must not stop the frame
            send_run(1'b1, $urandom_range(1, cap_gap + 1));
        end
        send_run(1'b0, $urandom_range(1, mark_top));
        send_run(1'b1, cap_gap + 2);
    endtask

    // waits until the block is quiet, then writes a new gap threshold
    task automatic write_gap(input logic [WIDTH_W-1:0] value);
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cap_gap = value;
    endtask

    // mostly well-formed frames with random widths, some cut short, some noise
    task automatic random_traffic(input int budget, input bit overflow_first);
        int stop_at;
        int kind;
        int pulses;
        stop_at = item_count + budget;
        while (item_count < stop_at)
        begin
            // some frames go through with no sender pauses at all
            sender_idling = ($urandom_range(0, 3) != 0);
            kind = overflow_first ? 0 : $urandom_range(0, 9);
            if (kind <= 6)
            begin
                send_item(OP_RESUME, 1'($urandom_range(0, 1)),
                          ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
                // enough short pulses to run past the end of the store
                pulses = overflow_first ? STORE_DEPTH / 2 + 2 : $urandom_range(3, 9);
                send_frame(pulses, overflow_first ? 1 : 5);
                overflow_first = 1'b0;
                if ($urandom_range(0, 3) == 0)
                    send_run(1'b0, $urandom_range(1, 2));
                // read back mostly stored entries, now and then one past the end
                repeat ($urandom_range(0, 3))
                    send_item(OP_READ, 1'($urandom_range(0, 1)),
                              (cap_count > 0 && $urandom_range(0, 3) != 0) ?
                              ADDR_W'($urandom_range(0, cap_count - 1)) :
                              ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
                case ($urandom_range(0, 9))
                    0: send_item(OP_PAUSE, 1'b0, '0);
                    1: send_item(OP_RESUME, 1'b1, '0);
                    default: send_item(OP_HASH, 1'($urandom_range(0, 1)),
                                       ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
                endcase
            end
            else if (kind <= 8)
            begin
                // a frame broken off by whatever item comes along
                send_item(OP_RESUME, 1'b0, '0);
                send_run(1'b1, $urandom_range(1, cap_gap + 2));
                repeat ($urandom_range(0, 4))
                begin
                    send_run(1'b0, $urandom_range(1, 5));
                    send_run(1'b1, $urandom_range(1, cap_gap + 1));
                end
                send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
                if ($urandom_range(0, 1) == 0)
                    send_item(OP_HASH, 1'b0, '0);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
            end
        end
    endtask

    // results are sampled mid-cycle, away from the edges where they change
    always @(negedge clk)
    begin : result_check
        capture_result_t want;
        if (rst_n && done === 1'b1)
        begin
            result_count++;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with none expected, status %0d phase %0d total %0d",
                         $time, status, capture_phase, entry_total);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                    fail_count++;
                end
                if (capture_phase !== want.phase)
                begin
                    $display("%0t: capture_phase expected %0d, got %0d", $time, want.phase,
                             capture_phase);
                    fail_count++;
                end
                if (entry_total !== want.total)
                begin
                    $display("%0t: entry_total expected %0d, got %0d", $time, want.total,
                             entry_total);
                    fail_count++;
                end
                if (read_width !== want.width)
                begin
                    $display("%0t: read_width expected %0d, got %0d", $time, want.width,
                             read_width);
                    fail_count++;
                end
                if (hash_value !== want.hash)
                begin
                    $display("%0t: hash_value expected %h, got %h", $time, want.hash,
                             hash_value);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cap_phase = PH_IDLE;
        cap_timer = '0;
        cap_count = 0;
        cap_gap   = WIDTH_W'(GAP_RESET);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items under the threshold left by reset
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(DIRECTED_TABLE[r].op, DIRECTED_TABLE[r].lvl, DIRECTED_TABLE[r].idx,
                      DIRECTED_TABLE[r].typed, DIRECTED_TABLE[r].want);

        // smallest threshold, opening with a frame that overruns the store
        write_gap(GAP_MIN);
        random_traffic(150, 1'b1);

        write_gap(16'd5);
        random_traffic(110, 1'b0);

        write_gap(16'd9);
        random_traffic(90, 1'b0);

        // largest threshold: no space run here comes near it, so marks never
        // open a frame and the engine stays idle until paused
        write_gap(GAP_MAX);
        sender_idling = 1'b0;
        send_item(OP_RESUME, 1'b0, '0);
        send_run(1'b1, 8);
        send_run(1'b0, 2);
        send_run(1'b1, 3);
        send_run(1'b0, 1);
        send_item(OP_READ, 1'b0, '0);
        send_item(OP_READ, 1'b1, 7'd2);
        send_item(OP_HASH, 1'b0, '0);
        send_item(OP_PAUSE, 1'b0, '0);
        send_item(OP_READ, 1'b0, '0);
        send_item(OP_HASH, 1'b1, '0);

        write_gap(WIDTH_W'($urandom_range(2, 7)));
        random_traffic(80, 1'b0);

        // let the last results come in, then watch for stray strobes
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("items sent %0d, results checked %0d, frame hashes %0d, widths read %0d",
                 item_count, result_count, hash_ok_count, read_ok_count);
        $display("store filled %0d times; gap thresholds 100, 1, 5, 9, 65535 and one drawn",
                 store_full_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
